>>> rtl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared widths, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_rle_pkg;

  localparam int PIX_CNT_W   = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W    = QPTR_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BPP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = CFG_IDX_W'(1);

  // Packet header coding.
  localparam logic [7:0] RUN_BIAS    = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic                 four_bpp;
    logic [PIX_CNT_W-1:0] pixel_count;
  } cfg_t;

  // Result record; red sits in the lowest bits.
  typedef struct packed {
    logic       image_done;
    logic [7:0] repeat_count;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

endpackage

`default_nettype wire

>>> rtl/tga_rle_front.sv
// ----------------------------------------------------------------------------
// TGA RLE front end
// Parses packet headers, gathers pixel bytes and clamps run lengths to the
// pixels left in the image, then hands finished pixels to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_front (
  input  logic                clk,
  input  logic                rst,
  input  tga_rle_pkg::cfg_t   cfg,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                room,
  output logic                push,
  output tga_rle_pkg::pix_t   pix
);

  logic                              awaiting_header;
  logic                              packet_is_run;
  logic [7:0]                        packet_pixels_left;
  logic [1:0]                        byte_in_pixel;
  logic [23:0]                       pixel_bytes_held;
  logic [tga_rle_pkg::PIX_CNT_W-1:0] pixels_written;

  logic                              in_fire;
  logic                              borrow;
  logic [tga_rle_pkg::PIX_CNT_W-1:0] diff;
  logic [tga_rle_pkg::PIX_CNT_W-1:0] remaining;
  logic                              rem_zero;
  logic                              rem_small;
  logic [1:0]                        last_idx;
  logic                              pixel_end;
  logic [23:0]                       held_merge;
  logic [7:0]                        run_count;
  logic [7:0]                        count;
  logic                              emit;
  logic [7:0]                        left_dec;

  assign in_fire = in_valid && room;

  // Pixels still missing from the image; zero once it is complete.
  assign {borrow, diff} = {1'b0, cfg.pixel_count} - {1'b0, pixels_written};
  assign remaining = borrow ? '0 : diff;
  assign rem_zero  = (remaining == '0);
  assign rem_small = (remaining[tga_rle_pkg::PIX_CNT_W-1:8] == '0);

  assign last_idx  = cfg.four_bpp ? 2'd3 : 2'd2;
  assign pixel_end = !awaiting_header && (byte_in_pixel >= last_idx);

  always_comb begin
    held_merge = pixel_bytes_held;
    case (byte_in_pixel)
      2'd0:    held_merge[7:0]   = in_byte;
      2'd1:    held_merge[15:8]  = in_byte;
      2'd2:    held_merge[23:16] = in_byte;
      default: held_merge = pixel_bytes_held;
    endcase
  end

  assign run_count = (rem_small && (remaining[7:0] < packet_pixels_left)) ?
                     remaining[7:0] : packet_pixels_left;
  assign count     = packet_is_run ? run_count : 8'd1;
  // A run always holds at least one pixel, so both packet kinds emit while
  // the image still has room.
  assign emit      = pixel_end && !rem_zero;
  assign push      = in_fire && emit;
  assign left_dec  = packet_pixels_left - 8'd1;

  always_comb begin
    pix.red          = held_merge[23:16];
    pix.green        = held_merge[15:8];
    pix.blue         = held_merge[7:0];
    pix.alpha        = cfg.four_bpp ? in_byte : tga_rle_pkg::ALPHA_OPAQUE;
    pix.repeat_count = count;
    // The count never overshoots, so this result ends the image exactly
    // when it covers every pixel still missing.
    pix.image_done   = ({{(tga_rle_pkg::PIX_CNT_W-8){1'b0}}, count} == remaining);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_header    <= 1'b1;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      byte_in_pixel      <= '0;
      pixel_bytes_held   <= '0;
      pixels_written     <= '0;
    end else if (in_fire) begin
      if (awaiting_header) begin
        if (!rem_zero) begin
          packet_is_run      <= in_byte[7];
          packet_pixels_left <= in_byte[7] ? (in_byte - tga_rle_pkg::RUN_BIAS)
                                           : (in_byte + 8'd1);
          byte_in_pixel      <= '0;
          pixel_bytes_held   <= '0;
          awaiting_header    <= 1'b0;
        end
      end else if (!pixel_end) begin
        pixel_bytes_held <= held_merge;
        byte_in_pixel    <= byte_in_pixel + 2'd1;
      end else begin
        if (emit) begin
          pixels_written <= pixels_written +
                            {{(tga_rle_pkg::PIX_CNT_W-8){1'b0}}, count};
        end
        if (packet_is_run) begin
          packet_pixels_left <= '0;
          awaiting_header    <= 1'b1;
        end else begin
          packet_pixels_left <= left_dec;
          if (left_dec == '0) begin
            awaiting_header <= 1'b1;
          end
        end
        byte_in_pixel    <= '0;
        pixel_bytes_held <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> (pix.repeat_count != 8'd0))
    else $error("front pushed a result with a zero repeat count");

  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    awaiting_header |-> (byte_in_pixel == 2'd0 && pixel_bytes_held == 24'd0))
    else $error("pixel assembly state left over at a packet header");

  a_push_on_pixel: assert property (@(posedge clk) disable iff (rst)
    push |-> (!awaiting_header && in_valid && room))
    else $error("result pushed without a closing pixel beat");
`endif

endmodule

`default_nettype wire

>>> rtl/tga_rle_back.sv
// ----------------------------------------------------------------------------
// TGA RLE back end
// Holds finished pixels in a short queue and shows them on the output stream,
// so the parser takes bytes while the sink stalls, until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tga_rle_pkg::pix_t pix_in,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tga_rle_pkg::pix_t pix_out
);

  tga_rle_pkg::pix_t                 mem [tga_rle_pkg::QUEUE_DEPTH];
  logic [tga_rle_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tga_rle_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tga_rle_pkg::QLEVEL_W-1:0]  level;
  logic                              pop;

  assign room      = (level != tga_rle_pkg::QLEVEL_W'(tga_rle_pkg::QUEUE_DEPTH));
  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;
  assign pix_out   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tga_rle_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tga_rle_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + tga_rle_pkg::QLEVEL_W'(1);
        2'b01:   level <= level - tga_rle_pkg::QLEVEL_W'(1);
        default: level <= level;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= tga_rle_pkg::QLEVEL_W'(tga_rle_pkg::QUEUE_DEPTH))
    else $error("result queue level beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("result pushed into a full queue");

  a_level_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (level == $past(level) + tga_rle_pkg::QLEVEL_W'(1)))
    else $error("queue level did not follow a lone push");
`endif

endmodule

`default_nettype wire

>>> rtl/tga_rle_pixel_decoder.sv
// A pixel's result is queued on its last byte beat; m_tvalid shows the queue head.
// Throughput: one byte beat per cycle while s_tready is high; a run result takes 4 or 5 beats.
// A four-entry result queue lets the byte input keep running while m_tready is low,
// until four results wait; then s_tready drops until a result leaves.
// Reset (rst, synchronous): parser waits for a packet header, image count and queue
// clear, registers go to 24-bit pixels and a pixel count of one.
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes the run-length coded TGA pixel stream into RGBA results with a
// repeat count, one byte beat in per cycle while s_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder (
  input  logic                               clk,
  input  logic                               rst,
  // Byte stream in.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // stream_byte
  // Pixel results out.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [39:0]                        m_tdata,   // red, green, blue, alpha, repeat_count
  output logic                               m_tlast,   // image_done
  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data
);

  tga_rle_pkg::cfg_t cfg;
  tga_rle_pkg::pix_t front_pix;
  tga_rle_pkg::pix_t back_pix;
  logic              push;
  logic              room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bpp    <= 1'b0;
      cfg.pixel_count <= tga_rle_pkg::PIX_CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tga_rle_pkg::CFG_FOUR_BPP:    cfg.four_bpp    <= cfg_data[0];
        tga_rle_pkg::CFG_PIXEL_COUNT: cfg.pixel_count <= cfg_data[tga_rle_pkg::PIX_CNT_W-1:0];
        default:                      cfg <= cfg;
      endcase
    end
  end

  assign s_tready = room;

  tga_rle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .room     (room),
    .push     (push),
    .pix      (front_pix)
  );

  tga_rle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pix_in    (front_pix),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pix_out   (back_pix)
  );

  assign m_tdata = back_pix[39:0];
  assign m_tlast = back_pix.image_done;

endmodule

`default_nettype wire

>>> tb/tga_rle_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder checker
// Watches the byte, pixel and register channels of the decoder. It keeps its
// own copy of the packet parser and image counter, and works out the pixel
// result that each accepted byte beat should produce. It then compares every
// pixel beat with the oldest expected result.
// ----------------------------------------------------------------------------

module tga_rle_pixel_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // stream_byte
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [39:0]                        m_tdata,   // red, green, blue, alpha, repeat_count
  input  logic                               m_tlast,   // image_done
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                 mismatches,
  output int                                 results_pending,
  output logic [tga_rle_pkg::PIX_CNT_W-1:0]  pixels_done,
  output int                                 bytes_decoded,
  output int                                 results_checked
);

  import tga_rle_pkg::*;

  logic                 mode32;
  logic [PIX_CNT_W-1:0] image_size;
  logic                 want_header;
  logic                 in_run;
  logic [7:0]           packet_left;
  logic [1:0]           byte_idx;
  logic [23:0]          bgr_held;
  pix_t                 expected_pixels[$];

  task automatic queue_pixel(input logic [7:0] last_byte, input logic [7:0] span);
    pix_t px;
    px.red          = bgr_held[23:16];
    px.green        = bgr_held[15:8];
    px.blue         = bgr_held[7:0];
    px.alpha        = mode32 ? last_byte : ALPHA_OPAQUE;
    px.repeat_count = span;
    pixels_done     = pixels_done + PIX_CNT_W'(span);
    px.image_done   = (pixels_done == image_size);
    expected_pixels.push_back(px);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [PIX_CNT_W:0] room;
    logic [PIX_CNT_W:0] span;
    logic [1:0]         last_idx;
    last_idx = mode32 ? 2'd3 : 2'd2;
    if (want_header) begin
      // A finished image swallows every further header byte.
      if (pixels_done >= image_size) return;
      bytes_decoded++;
      in_run      = b[7];
      packet_left = b[7] ? b - RUN_BIAS : b + 8'd1;
      byte_idx    = '0;
      bgr_held    = '0;
      want_header = 1'b0;
      return;
    end
    bytes_decoded++;
    if (byte_idx < 2'd3) bgr_held = bgr_held | (24'(b) << (8 * byte_idx));
    if (byte_idx < last_idx) begin
      byte_idx = byte_idx + 2'd1;
      return;
    end
    room = (pixels_done < image_size) ? image_size - pixels_done : '0;
    if (in_run) begin
      span = packet_left;
      if (span > room) span = room;
      if (span != 0) queue_pixel(b, span[7:0]);
      packet_left = '0;
      want_header = 1'b1;
    end else begin
      // Raw pixels past the end of the image are eaten without a result.
      if (room != 0) queue_pixel(b, 8'd1);
      packet_left = packet_left - 8'd1;
      if (packet_left == 0) want_header = 1'b1;
    end
    byte_idx = '0;
    bgr_held = '0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pix_t want;
    pix_t got;
    if (rst) begin
      mode32          = 1'b0;
      image_size      = PIX_CNT_W'(1);
      want_header     = 1'b1;
      in_run          = 1'b0;
      packet_left     = '0;
      byte_idx        = '0;
      bgr_held        = '0;
      pixels_done     = '0;
      mismatches      = 0;
      bytes_decoded   = 0;
      results_checked = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FOUR_BPP) mode32 = cfg_data[0];
        else if (cfg_index == CFG_PIXEL_COUNT) image_size = cfg_data[PIX_CNT_W-1:0];
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel beat with no result expected: data %h last %b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          got  = pix_t'({m_tlast, m_tdata});
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("repeat_count", want.repeat_count, got.repeat_count);
          check_field("image_done", 8'(want.image_done), 8'(got.image_done));
          results_checked++;
        end
      end
    end
    results_pending = expected_pixels.size();
  end

endmodule

>>> tb/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Drives packet streams into the decoder under both pixel sizes and a range
// of image sizes, with random gaps and back-pressure. The checker beside the
// decoder predicts and compares each pixel result; this module gives the
// verdict.
// ----------------------------------------------------------------------------

module tb_tga_rle_pixel_decoder;

  import tga_rle_pkg::*;

  localparam int TOTAL_BYTES    = 1600;
  localparam int QUIET_FROM     = TOTAL_BYTES - 250;
  localparam int PHASE_BYTES    = 150;
  localparam int PRESSURE_PHASE = 2;
  localparam int LONG_HOLD      = 80;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    mismatches;
  int                    results_pending;
  logic [PIX_CNT_W-1:0]  pixels_done;
  int                    bytes_decoded;
  int                    results_checked;

  logic                  src_gaps;
  logic                  sink_gaps;
  logic                  long_hold;
  logic                  four_mode;
  int                    reg_writes;
  int                    stall_cycles;

  tga_rle_pixel_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_pixel_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_pending (results_pending),
    .pixels_done     (pixels_done),
    .bytes_decoded   (bytes_decoded),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("No beat accepted for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, results_pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : pixel_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == CFG_FOUR_BPP) four_mode = val[0];
    reg_writes++;
  endtask

  task automatic set_regs(input logic four, input logic [PIX_CNT_W-1:0] count);
    write_reg(CFG_FOUR_BPP, CFG_DATA_W'(four));
    write_reg(CFG_PIXEL_COUNT, count);
  endtask

  // Stops the byte stream, waits until every predicted pixel has come out,
  // then lets the decoder settle with some margin.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed packets; now and then a stray byte or a packet cut short.
  task automatic send_packet();
    logic [7:0] hdr;
    int         pick;
    int         pix;
    int         nbytes;
    pick = $urandom_range(0, 31);
    if (pick == 0) begin
      send_byte(8'($urandom));
      return;
    end
    if (pick <= 12) hdr = 8'($urandom_range(0, 7));
    else if (pick <= 14) hdr = 8'($urandom_range(0, 127));
    else if (pick <= 26) hdr = 8'($urandom_range(128, 135));
    else hdr = 8'($urandom_range(128, 255));
    pix    = hdr[7] ? 1 : int'(hdr) + 1;
    nbytes = pix * (four_mode ? 4 : 3);
    if ($urandom_range(0, 19) == 0) nbytes = $urandom_range(0, nbytes - 1);
    send_byte(hdr);
    repeat (nbytes) send_byte(8'($urandom));
  endtask

  initial begin : stimulus
    int                   phase;
    int                   phase_end;
    logic                 gaps_on;
    logic [PIX_CNT_W-1:0] phase_count;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    src_gaps   = 1'b1;
    sink_gaps  = 1'b1;
    long_hold  = 1'b0;
    four_mode  = 1'b0;
    reg_writes = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers: a 128-pixel run into a one-pixel image, then a header
    // that arrives after the image is complete.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h05);

    // 32-bit pixels: a two-pixel raw packet where only one pixel fits.
    quiesce();
    set_regs(1'b1, pixels_done + 1);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);

    // Pixel size drops to 24 bits halfway through a run pixel; the run is
    // clamped to the three pixels left.
    quiesce();
    write_reg(CFG_PIXEL_COUNT, pixels_done + 3);
    send_byte(8'h84);
    send_byte(8'h11);
    quiesce();
    write_reg(CFG_FOUR_BPP, CFG_DATA_W'(0));
    send_byte(8'h22);
    send_byte(8'h33);

    // A one-pixel raw packet, then a run whose image size is cut to zero
    // remaining pixels before its pixel arrives.
    quiesce();
    write_reg(CFG_PIXEL_COUNT, pixels_done + 10);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    quiesce();
    write_reg(CFG_PIXEL_COUNT, pixels_done);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hC3);

    // Write to a register that does not exist, then an empty image.
    quiesce();
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_PIXEL_COUNT, '0);
    send_byte(8'h00);
    send_byte(8'h80);

    phase = 0;
    while (bytes_decoded < TOTAL_BYTES) begin
      quiesce();
      gaps_on = ($urandom_range(0, 3) != 0) && (phase != PRESSURE_PHASE);
      if (phase == PRESSURE_PHASE) begin
        phase_count = '1;
      end else begin
        case ($urandom_range(0, 7))
          0:       phase_count = '1;
          1:       phase_count = pixels_done;
          2:       phase_count = pixels_done + $urandom_range(1, 8);
          default: phase_count = pixels_done + $urandom_range(1, 400);
        endcase
      end
      if ($urandom_range(0, 2) == 0) write_reg(CFG_PIXEL_COUNT, phase_count);
      else set_regs(1'($urandom_range(0, 1)), phase_count);
      // The sink holds off while bytes keep coming, so the result queue fills
      // and the byte input stalls.
      if (phase == PRESSURE_PHASE) long_hold = 1'b1;
      phase_end = bytes_decoded + PHASE_BYTES;
      while (bytes_decoded < phase_end && bytes_decoded < TOTAL_BYTES &&
             pixels_done < phase_count) begin
        src_gaps  = gaps_on && (bytes_decoded < QUIET_FROM);
        sink_gaps = src_gaps;
        send_packet();
      end
      if (pixels_done >= phase_count) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      phase++;
    end

    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    quiesce();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Decoded %0d stream bytes into %0d checked pixel results, with %0d register",
             bytes_decoded, results_checked, reg_writes);
    $display("writes over %0d random phases in 24- and 32-bit modes, with clamped runs,",
             phase);
    $display("dropped raw pixels, finished images and a long output stall.");
    if (results_pending != 0) $error("%0d pixel results never arrived", results_pending);
    if (mismatches == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tga_rle_pkg.sv
rtl/tga_rle_front.sv
rtl/tga_rle_back.sv
rtl/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_checker.sv
tb/tb_tga_rle_pixel_decoder.sv
